@@ design/host_power_cycle_timer_assert.svh @@
// ----------------------------------------------------------------------------
// host power cycle timer assertion macros
// concurrent assertion wrappers shared by the checker
// ----------------------------------------------------------------------------
`ifndef HOST_POWER_CYCLE_TIMER_ASSERT_SVH
`define HOST_POWER_CYCLE_TIMER_ASSERT_SVH

// checked outside reset
`define HPCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HPCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/hpct_pkg.sv @@
// ----------------------------------------------------------------------------
// hpct_pkg
// types and constants of the host power cycle timer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpct_pkg;

  localparam int unsigned PADDR_W = 4;

  localparam logic [15:0] FORCE_OFF_RST   = 16'd300;
  localparam logic [15:0] DEFAULT_OFF_RST = 16'd1800;
  localparam logic [7:0]  POWEROFF_RST    = 8'h81;
  localparam logic [5:0]  WRITE_BYTES     = 6'd3;

  localparam logic [1:0] REG_FORCE_OFF   = 2'd0;
  localparam logic [1:0] REG_DEFAULT_OFF = 2'd1;
  localparam logic [1:0] REG_POWEROFF    = 2'd2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_COMMAND  = 2'd1,
    EV_FORCED   = 2'd2,
    EV_RESTORED = 2'd3
  } event_e;

  typedef struct packed {
    logic       op;
    logic [5:0] byte_count;
    logic [7:0] command;
    logic [7:0] duration_low;
    logic [7:0] duration_high;
  } req_t;

  typedef struct packed {
    logic [15:0] force_off_after;
    logic [15:0] default_off_time;
    logic [7:0]  poweroff_code;
  } cfg_t;

endpackage

@@ design/hpct_if.sv @@
// ----------------------------------------------------------------------------
// hpct channel interfaces
// request and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hpct_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [5:0] byte_count;
  logic [7:0] command;
  logic [7:0] duration_low;
  logic [7:0] duration_high;

  modport source (output valid, op, byte_count, command, duration_low, duration_high,
                  input ready);
  modport sink (input valid, op, byte_count, command, duration_low, duration_high,
                output ready);
endinterface

interface hpct_res_if;
  logic       valid;
  logic       ready;
  logic       power_enable;
  logic [1:0] event_res;

  modport source (output valid, power_enable, event_res, input ready);
  modport sink (input valid, power_enable, event_res, output ready);
endinterface

@@ design/hpct_regs.sv @@
// ----------------------------------------------------------------------------
// hpct_regs
// apb configuration registers of the host power cycle timer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpct_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hpct_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output hpct_pkg::cfg_t               cfg_o
);
  import hpct_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_off_after  <= FORCE_OFF_RST;
      cfg_q.default_off_time <= DEFAULT_OFF_RST;
      cfg_q.poweroff_code    <= POWEROFF_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FORCE_OFF:   cfg_q.force_off_after  <= pwdata[15:0];
        REG_DEFAULT_OFF: cfg_q.default_off_time <= pwdata[15:0];
        REG_POWEROFF:    cfg_q.poweroff_code    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FORCE_OFF:   prdata = {16'd0, cfg_q.force_off_after};
      REG_DEFAULT_OFF: prdata = {16'd0, cfg_q.default_off_time};
      REG_POWEROFF:    prdata = {24'd0, cfg_q.poweroff_code};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/hpct_in_stage.sv @@
// ----------------------------------------------------------------------------
// hpct_in_stage
// input register of the request channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpct_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  hpct_req_if.sink       req_i,
  output logic           valid_o,
  output hpct_pkg::req_t req_o,
  input  logic           take_i
);
  import hpct_pkg::*;

  logic valid_q;
  req_t req_q;
  logic load;

  assign req_i.ready = !valid_q || take_i;
  assign load        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q.op            <= req_i.op;
      req_q.byte_count    <= req_i.byte_count;
      req_q.command       <= req_i.command;
      req_q.duration_low  <= req_i.duration_low;
      req_q.duration_high <= req_i.duration_high;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

@@ design/hpct_core.sv @@
// ----------------------------------------------------------------------------
// hpct_core
// power state update and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpct_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hpct_pkg::cfg_t cfg_i,
  input  logic           valid_i,
  input  hpct_pkg::req_t req_i,
  output logic           take_o,
  hpct_res_if.source     res_o
);
  import hpct_pkg::*;

  logic        load_on_q, load_on_d;
  logic [16:0] on_elapsed_q, on_elapsed_d;
  logic [15:0] off_elapsed_q, off_elapsed_d;
  logic [15:0] off_length_q, off_length_d;
  logic [15:0] last_length_q, last_length_d;
  logic [15:0] pending_length_q, pending_length_d;

  logic        res_valid_q;
  logic        power_q;
  event_e      event_q, event_d;

  logic [15:0] duration;
  logic        cmd_ok;
  logic [16:0] on_inc;
  logic [15:0] off_inc;

  assign take_o   = valid_i && (!res_valid_q || res_o.ready);
  assign duration = {req_i.duration_high, req_i.duration_low};
  assign cmd_ok   = (req_i.byte_count == WRITE_BYTES) && (req_i.command == cfg_i.poweroff_code);
  assign on_inc   = (&on_elapsed_q) ? on_elapsed_q : on_elapsed_q + 17'd1;
  assign off_inc  = (&off_elapsed_q) ? off_elapsed_q : off_elapsed_q + 16'd1;

  always_comb begin
    load_on_d        = load_on_q;
    on_elapsed_d     = on_elapsed_q;
    off_elapsed_d    = off_elapsed_q;
    off_length_d     = off_length_q;
    last_length_d    = last_length_q;
    pending_length_d = pending_length_q;
    event_d          = EV_NONE;
    if (req_i.op == OP_WRITE) begin
      if (cmd_ok) begin
        pending_length_d = duration;
        if (load_on_q && (duration != 16'd0)) begin
          last_length_d    = duration;
          pending_length_d = 16'd0;
          load_on_d        = 1'b0;
          off_length_d     = duration;
          off_elapsed_d    = 16'd0;
          on_elapsed_d     = 17'd0;
          event_d          = EV_COMMAND;
        end
      end
    end else if (load_on_q) begin
      on_elapsed_d = on_inc;
      if (on_inc > {1'b0, cfg_i.force_off_after}) begin
        load_on_d     = 1'b0;
        off_length_d  = (last_length_q != 16'd0) ? last_length_q : cfg_i.default_off_time;
        off_elapsed_d = 16'd0;
        on_elapsed_d  = 17'd0;
        event_d       = EV_FORCED;
      end
    end else begin
      off_elapsed_d = off_inc;
      if (off_inc >= off_length_q) begin
        on_elapsed_d  = 17'd0;
        off_elapsed_d = 16'd0;
        if (pending_length_q != 16'd0) begin
          last_length_d    = pending_length_q;
          pending_length_d = 16'd0;
          off_length_d     = pending_length_q;
          event_d          = EV_COMMAND;
        end else begin
          load_on_d = 1'b1;
          event_d   = EV_RESTORED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_on_q        <= 1'b1;
      on_elapsed_q     <= 17'd0;
      off_elapsed_q    <= 16'd0;
      off_length_q     <= 16'd0;
      last_length_q    <= 16'd0;
      pending_length_q <= 16'd0;
      res_valid_q      <= 1'b0;
    end else begin
      if (take_o) begin
        load_on_q        <= load_on_d;
        on_elapsed_q     <= on_elapsed_d;
        off_elapsed_q    <= off_elapsed_d;
        off_length_q     <= off_length_d;
        last_length_q    <= last_length_d;
        pending_length_q <= pending_length_d;
        res_valid_q      <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      power_q <= load_on_d;
      event_q <= event_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.power_enable = power_q;
  assign res_o.event_res    = event_q;

endmodule

@@ design/host_power_cycle_timer.sv @@
// ----------------------------------------------------------------------------
// host_power_cycle_timer
// host load power switch with commanded and watchdog forced off periods
// ----------------------------------------------------------------------------
// requests come in on req_i: op 0 is a one-second tick, op 1 a received bus
// write carrying byte count, command byte and a 16-bit off duration.
// every request gives one result on res_o: power_enable after the request
// and event_res (none, commanded off, forced off, power restored).
// a request passes the input register, then the state update into the
// result register. throughput is one request per cycle while res_o
// does not stall, limited by the single state update.
// the input register takes a new request while a result waits to be taken;
// when res_o stalls, both registers fill and req_i.ready drops.
// reset powers the load, clears all counters and pending requests and
// loads the register defaults (force off after 300, default off 1800,
// power off code 0x81). registers sit on the apb port at 0x0, 0x4, 0x8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module host_power_cycle_timer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  hpct_req_if.sink                     req_i,
  hpct_res_if.source                   res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hpct_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hpct_pkg::*;

  cfg_t cfg;
  req_t stage_req;
  logic stage_valid;
  logic stage_take;

  hpct_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hpct_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .valid_o (stage_valid),
    .req_o   (stage_req),
    .take_i  (stage_take)
  );

  hpct_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (stage_valid),
    .req_i   (stage_req),
    .take_o  (stage_take),
    .res_o   (res_o)
  );

endmodule

@@ design/hpct_checker.sv @@
// ----------------------------------------------------------------------------
// hpct_checker
// port level assertions of the host power cycle timer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "host_power_cycle_timer_assert.svh"

module hpct_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_power,
  input logic [1:0]                   res_event,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [hpct_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready
);
  import hpct_pkg::*;

  `HPCT_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
  `HPCT_ASSERT(a_event_power, res_valid && (res_event == EV_COMMAND || res_event == EV_FORCED || res_event == EV_RESTORED) |-> (res_power == (res_event == EV_RESTORED)), "event and power enable disagree")
  `HPCT_ASSERT(a_cfg_readback, (psel && penable && pwrite && pready && paddr == 4'h0) ##1 (paddr == 4'h0) |-> prdata == {16'd0, $past(pwdata[15:0])}, "register readback mismatch")
  `HPCT_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind host_power_cycle_timer hpct_checker u_hpct_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_power (res_o.power_enable),
  .res_event (res_o.event_res),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
